// File: hw/rtl/hrpbc_pkg.sv
// Package for the red pixel band counter: word types, configuration layout,
// mask geometry and the widths of the color arithmetic. Depends on nothing.
`default_nettype none

package hrpbc_pkg;

  // Mask geometry and band bookkeeping.
  localparam int MASK_COLS = 20;
  localparam int MASK_ROWS = 15;
  localparam int NUM_BANDS = 5;
  localparam int CNT_W     = 6;
  localparam int BEST_W    = 3;
  localparam logic [CNT_W-1:0] COUNT_MAX = 6'd63;

  // Configuration port widths.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 9;

  // The weighted hue numerator reaches 360 * 255; the hue bound products with d reach 511 * 255.
  typedef logic [16:0] hue_t;
  // Percent products reach 127 * 256 and 255 * 100.
  typedef logic [14:0] pct_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HUE_LOW_MAX    = 3'd0,
    REG_HUE_HIGH_MIN   = 3'd1,
    REG_SAT_MIN        = 3'd2,
    REG_SAT_MAX        = 3'd3,
    REG_VAL_MIN        = 3'd4,
    REG_VAL_MAX        = 3'd5,
    REG_GOAL_THRESHOLD = 3'd6
  } cfg_reg_e;

  typedef struct packed {
    logic [8:0] hue_low_max;
    logic [8:0] hue_high_min;
    logic [6:0] sat_min;
    logic [6:0] sat_max;
    logic [6:0] val_min;
    logic [6:0] val_max;
    logic [5:0] goal_threshold;
  } cfg_t;

  typedef struct packed {
    logic       frame_start;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [4:0] column;
    logic [4:0] row;
  } pixel_t;

  typedef struct packed {
    logic             is_red;
    logic [CNT_W-1:0] band0_count;
    logic [CNT_W-1:0] band1_count;
    logic [CNT_W-1:0] band2_count;
    logic [CNT_W-1:0] band3_count;
    logic [CNT_W-1:0] band4_count;
    logic             goal_seen;
    logic [2:0]       best_band;
  } result_t;

  // Color terms handed from the prep stage to the window stage.
  typedef struct packed {
    logic       gray;
    logic [7:0] mx;
    logic [7:0] d;
    hue_t       hn;
  } hsv_t;

  // Position and flag that travel alongside the color terms.
  typedef struct packed {
    logic       frame_start;
    logic [4:0] column;
    logic [4:0] row;
  } pos_t;

endpackage

`default_nettype wire

// File: hw/rtl/hrpbc_hsv_prep.sv
// Max, min, spread and weighted hue numerator of one pixel.
// Depends on hrpbc_pkg.
`default_nettype none

module hrpbc_hsv_prep (
  input  hrpbc_pkg::pixel_t pix_i,
  output hrpbc_pkg::hsv_t   hsv_o
);

  logic [7:0] r, g, b, mx, mn, d;
  hrpbc_pkg::hue_t r_w, g_w, b_w, d_w, hn;

  always_comb begin
    r = pix_i.red;
    g = pix_i.green;
    b = pix_i.blue;
    mx = r;
    if (g > mx) mx = g;
    if (b > mx) mx = b;
    mn = r;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    d = mx - mn;
    r_w = hrpbc_pkg::hue_t'(r);
    g_w = hrpbc_pkg::hue_t'(g);
    b_w = hrpbc_pkg::hue_t'(b);
    d_w = hrpbc_pkg::hue_t'(d);
    // Ties for the maximum go to red, then green. Every branch stays
    // non-negative, so the subtraction never wraps.
    if (mx == r) begin
      if (g >= b) begin
        hn = 17'd60 * (g_w - b_w);
      end else begin
        hn = 17'd360 * d_w - 17'd60 * (b_w - g_w);
      end
    end else if (mx == g) begin
      hn = 17'd120 * d_w + 17'd60 * b_w - 17'd60 * r_w;
    end else begin
      hn = 17'd240 * d_w + 17'd60 * r_w - 17'd60 * g_w;
    end
    hsv_o.gray = (mx == mn);
    hsv_o.mx   = mx;
    hsv_o.d    = d;
    hsv_o.hn   = hn;
  end

endmodule

`default_nettype wire

// File: hw/rtl/hrpbc_window.sv
// Hue, saturation and value window tests by cross-multiplied compares.
// Depends on hrpbc_pkg.
`default_nettype none

module hrpbc_window (
  input  hrpbc_pkg::hsv_t hsv_i,
  input  hrpbc_pkg::cfg_t cfg_i,
  output logic            is_red_o
);

  hrpbc_pkg::hue_t lo_p, hi_p;
  hrpbc_pkg::pct_t d100, smin_p, smax_p, v100, vmin_p, vmax_p;
  logic hue_ok, sat_ok, val_ok;

  always_comb begin
    lo_p   = hrpbc_pkg::hue_t'(cfg_i.hue_low_max) * hrpbc_pkg::hue_t'(hsv_i.d);
    hi_p   = hrpbc_pkg::hue_t'(cfg_i.hue_high_min) * hrpbc_pkg::hue_t'(hsv_i.d);
    d100   = hrpbc_pkg::pct_t'(hsv_i.d) * 15'd100;
    smin_p = hrpbc_pkg::pct_t'(cfg_i.sat_min) * hrpbc_pkg::pct_t'(hsv_i.mx);
    smax_p = hrpbc_pkg::pct_t'(cfg_i.sat_max) * hrpbc_pkg::pct_t'(hsv_i.mx);
    v100   = hrpbc_pkg::pct_t'(hsv_i.mx) * 15'd100;
    vmin_p = {cfg_i.val_min, 8'd0};
    vmax_p = {cfg_i.val_max, 8'd0};
    hue_ok = (hsv_i.hn <= lo_p) || (hsv_i.hn >= hi_p);
    sat_ok = (d100 >= smin_p) && (d100 <= smax_p);
    val_ok = (v100 >= vmin_p) && (v100 <= vmax_p);
    is_red_o = !hsv_i.gray && hue_ok && sat_ok && val_ok;
  end

endmodule

`default_nettype wire

// File: hw/rtl/hrpbc_band_tracker.sv
// Red mask, per-band counts, goal flag and best band selection.
// Depends on hrpbc_pkg.
`default_nettype none

module hrpbc_band_tracker (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   step_i,
  input  logic                   is_red_i,
  input  hrpbc_pkg::pos_t        pos_i,
  input  logic [5:0]             goal_threshold_i,
  output hrpbc_pkg::result_t     result_o
);

  logic [hrpbc_pkg::MASK_COLS-1:0] mask_q [hrpbc_pkg::MASK_ROWS];
  logic [hrpbc_pkg::MASK_COLS-1:0] mask_d [hrpbc_pkg::MASK_ROWS];
  logic [hrpbc_pkg::CNT_W-1:0]     cnt_q  [hrpbc_pkg::NUM_BANDS];
  logic [hrpbc_pkg::CNT_W-1:0]     cnt_d  [hrpbc_pkg::NUM_BANDS];
  logic [hrpbc_pkg::MASK_ROWS-1:0] row_sel;
  logic [hrpbc_pkg::MASK_COLS-1:0] col_sel;
  logic [hrpbc_pkg::NUM_BANDS-1:0] band_sel;
  logic hit, was_set, newly;
  logic goal;
  logic [hrpbc_pkg::BEST_W-1:0] best;

  always_comb begin
    for (int r = 0; r < hrpbc_pkg::MASK_ROWS; r++) begin
      row_sel[r] = (int'(pos_i.row) == r);
    end
    for (int c = 0; c < hrpbc_pkg::MASK_COLS; c++) begin
      col_sel[c] = (int'(pos_i.column) == c);
    end
    band_sel[0] = (pos_i.column < 5'd4);
    band_sel[1] = (pos_i.column >= 5'd4)  && (pos_i.column < 5'd8);
    band_sel[2] = (pos_i.column >= 5'd8)  && (pos_i.column < 5'd12);
    band_sel[3] = (pos_i.column >= 5'd12) && (pos_i.column < 5'd16);
    band_sel[4] = (pos_i.column >= 5'd16);
    hit = is_red_i && (|row_sel) && (|col_sel);

    // A frame start wipes the mask and the counts before this pixel lands.
    was_set = 1'b0;
    for (int r = 0; r < hrpbc_pkg::MASK_ROWS; r++) begin
      mask_d[r] = pos_i.frame_start ? '0 : mask_q[r];
      was_set   = was_set | (row_sel[r] && |(mask_d[r] & col_sel));
      if (hit && row_sel[r]) begin
        mask_d[r] = mask_d[r] | col_sel;
      end
    end
    newly = hit && !was_set;

    for (int k = 0; k < hrpbc_pkg::NUM_BANDS; k++) begin
      cnt_d[k] = pos_i.frame_start ? '0 : cnt_q[k];
      if (newly && band_sel[k] && (cnt_d[k] < hrpbc_pkg::COUNT_MAX)) begin
        cnt_d[k] = cnt_d[k] + 6'd1;
      end
    end

    goal = 1'b1;
    best = '0;
    for (int k = 0; k < hrpbc_pkg::NUM_BANDS; k++) begin
      if (cnt_d[k] <= goal_threshold_i) goal = 1'b0;
      if (cnt_d[k] > cnt_d[best]) best = hrpbc_pkg::BEST_W'(k);
    end

    result_o.is_red      = is_red_i;
    result_o.band0_count = cnt_d[0];
    result_o.band1_count = cnt_d[1];
    result_o.band2_count = cnt_d[2];
    result_o.band3_count = cnt_d[3];
    result_o.band4_count = cnt_d[4];
    result_o.goal_seen   = goal;
    result_o.best_band   = best;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < hrpbc_pkg::MASK_ROWS; r++) mask_q[r] <= '0;
      for (int k = 0; k < hrpbc_pkg::NUM_BANDS; k++) cnt_q[k] <= '0;
    end else if (step_i) begin
      for (int r = 0; r < hrpbc_pkg::MASK_ROWS; r++) mask_q[r] <= mask_d[r];
      for (int k = 0; k < hrpbc_pkg::NUM_BANDS; k++) cnt_q[k] <= cnt_d[k];
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/hsv_red_pixel_band_counter_top.sv
// Top level of the red pixel band counter: handshakes, configuration
// registers and the pipeline. Depends on hrpbc_pkg, hrpbc_hsv_prep,
// hrpbc_window and hrpbc_band_tracker.
`default_nettype none

//  Channel   Direction  Handshake               Payload
//  input     in         in_valid_i/in_stall_o   in_word_i  (pixel_t)
//  output    out        out_valid_o/out_stall_i out_word_o (result_t)
//  config    in         cfg_we_i                cfg_idx_i, cfg_wdata_i
//
//  One word is taken every clock cycle when the output side keeps up. Four
//  register stages (input, color terms, red flag, result) each hold one word,
//  and a stall on the output backs up through whichever stages are full, so
//  a new word is still taken while a result waits as long as a stage is free.
//  Reset clears the mask, the counts and the stage valid flags, and loads
//  the default windows.

module hsv_red_pixel_band_counter_top (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  hrpbc_pkg::pixel_t                   in_word_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output hrpbc_pkg::result_t                  out_word_o,
  input  logic                                cfg_we_i,
  input  logic [hrpbc_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [hrpbc_pkg::CFG_DATA_W-1:0]    cfg_wdata_i
);

  hrpbc_pkg::cfg_t    cfg_q;
  hrpbc_pkg::pixel_t  s1_pix_q;
  hrpbc_pkg::hsv_t    s2_hsv_q, hsv_d;
  hrpbc_pkg::pos_t    s2_pos_q, s3_pos_q;
  logic               s3_red_q, red_d;
  hrpbc_pkg::result_t out_q, result_d;
  logic s1_v_q, s2_v_q, s3_v_q, out_v_q;
  logic out_free, s3_free, s2_free, s1_free;
  logic s1_go, s2_go, s3_go, in_take;

  // Configuration writes. Codes past the list are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.hue_low_max    <= 9'd60;
      cfg_q.hue_high_min   <= 9'd300;
      cfg_q.sat_min        <= 7'd10;
      cfg_q.sat_max        <= 7'd100;
      cfg_q.val_min        <= 7'd15;
      cfg_q.val_max        <= 7'd90;
      cfg_q.goal_threshold <= 6'd30;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        hrpbc_pkg::REG_HUE_LOW_MAX:    cfg_q.hue_low_max    <= cfg_wdata_i;
        hrpbc_pkg::REG_HUE_HIGH_MIN:   cfg_q.hue_high_min   <= cfg_wdata_i;
        hrpbc_pkg::REG_SAT_MIN:        cfg_q.sat_min        <= cfg_wdata_i[6:0];
        hrpbc_pkg::REG_SAT_MAX:        cfg_q.sat_max        <= cfg_wdata_i[6:0];
        hrpbc_pkg::REG_VAL_MIN:        cfg_q.val_min        <= cfg_wdata_i[6:0];
        hrpbc_pkg::REG_VAL_MAX:        cfg_q.val_max        <= cfg_wdata_i[6:0];
        hrpbc_pkg::REG_GOAL_THRESHOLD: cfg_q.goal_threshold <= cfg_wdata_i[5:0];
        default: begin
        end
      endcase
    end
  end

  // A stage may load when it is empty or its word moves on this cycle.
  assign out_free = !out_v_q || !out_stall_i;
  assign s3_go    = s3_v_q && out_free;
  assign s3_free  = !s3_v_q || out_free;
  assign s2_go    = s2_v_q && s3_free;
  assign s2_free  = !s2_v_q || s3_free;
  assign s1_go    = s1_v_q && s2_free;
  assign s1_free  = !s1_v_q || s2_free;
  assign in_take  = in_valid_i && s1_free;

  assign in_stall_o  = !s1_free;
  assign out_valid_o = out_v_q;
  assign out_word_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      s3_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (s1_free)  s1_v_q  <= in_valid_i;
      if (s2_free)  s2_v_q  <= s1_go;
      if (s3_free)  s3_v_q  <= s2_go;
      if (out_free) out_v_q <= s3_go;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    if (in_take) s1_pix_q <= in_word_i;
    if (s1_go) begin
      s2_hsv_q             <= hsv_d;
      s2_pos_q.frame_start <= s1_pix_q.frame_start;
      s2_pos_q.column      <= s1_pix_q.column;
      s2_pos_q.row         <= s1_pix_q.row;
    end
    if (s2_go) begin
      s3_red_q <= red_d;
      s3_pos_q <= s2_pos_q;
    end
    if (s3_go) out_q <= result_d;
  end

  // Stage one: extremes, spread and hue numerator.
  hrpbc_hsv_prep u_prep (
    .pix_i (s1_pix_q),
    .hsv_o (hsv_d)
  );

  // Stage two: window products and compares.
  hrpbc_window u_window (
    .hsv_i    (s2_hsv_q),
    .cfg_i    (cfg_q),
    .is_red_o (red_d)
  );

  // Stage three: the mask and counts advance exactly when the word moves
  // into the result register, so every pixel updates the state once.
  hrpbc_band_tracker u_tracker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .step_i           (s3_go),
    .is_red_i         (s3_red_q),
    .pos_i            (s3_pos_q),
    .goal_threshold_i (cfg_q.goal_threshold),
    .result_o         (result_d)
  );

endmodule

`default_nettype wire
